@@ hw/rtl/nnds_pkg.sv @@
// ----------------------------------------------------------------------------
// nnds_pkg
// Shared constants and types of the nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnds_pkg;

  localparam int MAX_SRC_DIM = 4096;
  localparam int MAX_DST_DIM = 512;

  localparam int PIXEL_W     = 32;
  localparam int SRC_RAW_W   = 13;
  localparam int DST_RAW_W   = 10;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [SRC_RAW_W-1:0] SRC_WIDTH_RESET  = 13'd1024;
  localparam logic [SRC_RAW_W-1:0] SRC_HEIGHT_RESET = 13'd768;
  localparam logic [DST_RAW_W-1:0] DST_WIDTH_RESET  = 10'd412;
  localparam logic [DST_RAW_W-1:0] DST_HEIGHT_RESET = 10'd176;

  localparam logic [PIXEL_W-1:0] OPAQUE_MASK = 32'hFF00_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ hw/rtl/nnds_front.sv @@
// ----------------------------------------------------------------------------
// nnds_front
// Holds the size registers, tracks the source position of each accepted word
// and decides whether it is a thumbnail pixel, with its index and frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module nnds_front #(
  parameter int MAX_SRC_DIM = nnds_pkg::MAX_SRC_DIM,
  parameter int MAX_DST_DIM = nnds_pkg::MAX_DST_DIM,
  parameter int IDX_W       = 2 * $clog2(nnds_pkg::MAX_DST_DIM)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [nnds_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [nnds_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               accept,
  input  wire logic [nnds_pkg::PIXEL_W-1:0]       in_pixel,
  output logic                                    q_push,
  output logic [nnds_pkg::PIXEL_W-1:0]            q_pixel,
  output logic [IDX_W-1:0]                        q_index,
  output logic                                    q_last
);

  localparam int SW_W  = $clog2(MAX_SRC_DIM + 1);
  localparam int DW_W  = $clog2(MAX_DST_DIM + 1);
  localparam int POS_W = $clog2(MAX_SRC_DIM);
  localparam int TW    = $clog2(MAX_SRC_DIM) + $clog2(MAX_DST_DIM) + 1;
  localparam int PW    = 2 * DW_W;
  localparam int CW0   = (SW_W > nnds_pkg::SRC_RAW_W) ? SW_W : nnds_pkg::SRC_RAW_W;
  localparam int CW    = (CW0 > DW_W) ? CW0 : DW_W;

  // Size registers as written.
  logic [nnds_pkg::SRC_RAW_W-1:0] src_width, src_width_next;
  logic [nnds_pkg::SRC_RAW_W-1:0] src_height, src_height_next;
  logic [nnds_pkg::DST_RAW_W-1:0] dst_width, dst_width_next;
  logic [nnds_pkg::DST_RAW_W-1:0] dst_height, dst_height_next;

  // Clamped sizes and the index of the last thumbnail pixel.
  logic [SW_W-1:0] eff_sw, eff_sw_next;
  logic [SW_W-1:0] eff_sh, eff_sh_next;
  logic [DW_W-1:0] eff_dw, eff_dw_next;
  logic [DW_W-1:0] eff_dh, eff_dh_next;
  logic [PW-1:0]   total_m1, total_m1_next;

  logic [CW-1:0] sw_c, sh_c, dw_c, dh_c;
  logic [PW-1:0] area;

  // Position state.
  logic [POS_W-1:0] src_col, src_col_next;
  logic [POS_W-1:0] src_row, src_row_next;
  logic [TW-1:0]    col_target, col_target_next;
  logic [TW-1:0]    col_limit, col_limit_next;
  logic [TW-1:0]    row_target, row_target_next;
  logic [TW-1:0]    row_limit, row_limit_next;
  logic             row_selected, row_selected_next;
  logic [IDX_W-1:0] out_count, out_count_next;

  logic restart;
  logic sel;
  logic col_end;
  logic row_end;

  assign restart = rst || cfg_write;

  always_comb begin
    src_width_next  = src_width;
    src_height_next = src_height;
    dst_width_next  = dst_width;
    dst_height_next = dst_height;
    if (rst) begin
      src_width_next  = nnds_pkg::SRC_WIDTH_RESET;
      src_height_next = nnds_pkg::SRC_HEIGHT_RESET;
      dst_width_next  = nnds_pkg::DST_WIDTH_RESET;
      dst_height_next = nnds_pkg::DST_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        nnds_pkg::REG_SRC_WIDTH:  src_width_next  = cfg_data[nnds_pkg::SRC_RAW_W-1:0];
        nnds_pkg::REG_SRC_HEIGHT: src_height_next = cfg_data[nnds_pkg::SRC_RAW_W-1:0];
        nnds_pkg::REG_DST_WIDTH:  dst_width_next  = cfg_data[nnds_pkg::DST_RAW_W-1:0];
        nnds_pkg::REG_DST_HEIGHT: dst_height_next = cfg_data[nnds_pkg::DST_RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the new sizes so the restart below already sees them.
  always_comb begin
    sw_c = CW'(src_width_next);
    sh_c = CW'(src_height_next);
    dw_c = CW'(dst_width_next);
    dh_c = CW'(dst_height_next);
    if (sw_c == CW'(0)) begin
      sw_c = CW'(1);
    end else if (sw_c > CW'(MAX_SRC_DIM)) begin
      sw_c = CW'(MAX_SRC_DIM);
    end
    if (sh_c == CW'(0)) begin
      sh_c = CW'(1);
    end else if (sh_c > CW'(MAX_SRC_DIM)) begin
      sh_c = CW'(MAX_SRC_DIM);
    end
    if (dw_c == CW'(0)) begin
      dw_c = CW'(1);
    end else if (dw_c > CW'(MAX_DST_DIM)) begin
      dw_c = CW'(MAX_DST_DIM);
    end
    if (dh_c == CW'(0)) begin
      dh_c = CW'(1);
    end else if (dh_c > CW'(MAX_DST_DIM)) begin
      dh_c = CW'(MAX_DST_DIM);
    end
    // A thumbnail never exceeds its source, so no source pixel is used twice.
    if (dw_c > sw_c) begin
      dw_c = sw_c;
    end
    if (dh_c > sh_c) begin
      dh_c = sh_c;
    end
    eff_sw_next   = SW_W'(sw_c);
    eff_sh_next   = SW_W'(sh_c);
    eff_dw_next   = DW_W'(dw_c);
    eff_dh_next   = DW_W'(dh_c);
    area          = PW'(eff_dw_next) * PW'(eff_dh_next);
    total_m1_next = area - PW'(1);
  end

  assign sel     = row_selected && (col_target < col_limit);
  assign col_end = (SW_W'(src_col) == (eff_sw - SW_W'(1)));
  assign row_end = (SW_W'(src_row) == (eff_sh - SW_W'(1)));

  always_comb begin
    src_col_next      = src_col;
    src_row_next      = src_row;
    col_target_next   = col_target;
    col_limit_next    = col_limit;
    row_target_next   = row_target;
    row_limit_next    = row_limit;
    row_selected_next = row_selected;
    out_count_next    = out_count;
    if (restart) begin
      src_col_next      = '0;
      src_row_next      = '0;
      col_target_next   = '0;
      col_limit_next    = TW'(eff_dw_next);
      row_target_next   = '0;
      row_limit_next    = TW'(eff_dh_next);
      row_selected_next = 1'b1;
      out_count_next    = '0;
    end else if (accept) begin
      if (sel) begin
        col_target_next = col_target + TW'(eff_sw);
        out_count_next  = out_count + IDX_W'(1);
      end
      col_limit_next = col_limit + TW'(eff_dw);
      src_col_next   = src_col + POS_W'(1);
      if (col_end) begin
        src_col_next    = '0;
        col_target_next = '0;
        col_limit_next  = TW'(eff_dw);
        if (row_selected) begin
          row_target_next = row_target + TW'(eff_sh);
        end
        row_limit_next = row_limit + TW'(eff_dh);
        src_row_next   = src_row + POS_W'(1);
        if (row_end) begin
          src_row_next    = '0;
          row_target_next = '0;
          row_limit_next  = TW'(eff_dh);
          out_count_next  = '0;
        end
        row_selected_next = row_target_next < row_limit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_width    <= src_width_next;
    src_height   <= src_height_next;
    dst_width    <= dst_width_next;
    dst_height   <= dst_height_next;
    eff_sw       <= eff_sw_next;
    eff_sh       <= eff_sh_next;
    eff_dw       <= eff_dw_next;
    eff_dh       <= eff_dh_next;
    total_m1     <= total_m1_next;
    src_col      <= src_col_next;
    src_row      <= src_row_next;
    col_target   <= col_target_next;
    col_limit    <= col_limit_next;
    row_target   <= row_target_next;
    row_limit    <= row_limit_next;
    row_selected <= row_selected_next;
    out_count    <= out_count_next;
  end

  assign q_push  = accept && sel;
  assign q_pixel = in_pixel;
  assign q_index = out_count;
  assign q_last  = (PW'(out_count) == total_m1);

endmodule

`default_nettype wire

@@ hw/rtl/nnds_queue.sv @@
// ----------------------------------------------------------------------------
// nnds_queue
// Short first-in first-out queue of selected words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nnds_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nnds_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW:0]      wr_ptr, wr_ptr_next;
  logic [AW:0]      rd_ptr, rd_ptr_next;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign rdata = slots[rd_ptr[AW-1:0]];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (push && !full) begin
      wr_ptr_next = wr_ptr + (AW+1)'(1);
    end
    if (pop && !empty) begin
      rd_ptr_next = rd_ptr + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr[AW-1:0]] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nnds_back.sv @@
// ----------------------------------------------------------------------------
// nnds_back
// Takes selected words from the queue, forces the pixel opaque and holds the
// result in the output register until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module nnds_back #(
  parameter int IDX_W = 2 * $clog2(nnds_pkg::MAX_DST_DIM)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire logic [nnds_pkg::PIXEL_W-1:0]  q_pixel,
  input  wire logic [IDX_W-1:0]              q_index,
  input  wire logic                          q_last,
  output logic                               q_pop,
  input  wire logic                          pop,
  output logic                               empty,
  output logic [nnds_pkg::PIXEL_W-1:0]       out_pixel,
  output logic [IDX_W-1:0]                   thumb_index,
  output logic                               last_of_frame
);

  logic out_valid, out_valid_next;
  logic load;

  // Refill whenever the register is free or is being emptied this cycle.
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load;
  assign empty = !out_valid;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (pop) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pixel     <= q_pixel | nnds_pkg::OPAQUE_MASK;
      thumb_index   <= q_index;
      last_of_frame <= q_last;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nearest_neighbour_downscaler_top.sv @@
// Path: a selected source word is written into the queue at the edge that accepts it,
// then loaded into the output register, from which it can be popped.
// Throughput: one source word per cycle while full is low; front position counters and the
// output register each take one word per cycle, and a four-word queue absorbs pop stalls.
// Reset: synchronous; sizes return to 1024x768 source and 412x176 thumbnail, the
// frame restarts and the queue and output register empty. Any size write restarts the frame.
// ----------------------------------------------------------------------------
// nearest_neighbour_downscaler_top
// Streaming nearest-neighbor thumbnail generator for raster-order ARGB pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbour_downscaler_top #(
  parameter int MAX_SRC_DIM = nnds_pkg::MAX_SRC_DIM,
  parameter int MAX_DST_DIM = nnds_pkg::MAX_DST_DIM,
  parameter int IDX_W       = 2 * $clog2(MAX_DST_DIM)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [nnds_pkg::PIXEL_W-1:0]      in_pixel,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [nnds_pkg::PIXEL_W-1:0]           out_pixel,
  output logic [IDX_W-1:0]                       thumb_index,
  output logic                                   last_of_frame,
  input  wire logic                              cfg_write,
  input  wire logic [nnds_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [nnds_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WORD_W = nnds_pkg::PIXEL_W + IDX_W + 1;

  logic                         accept;
  logic                         f_push;
  logic [nnds_pkg::PIXEL_W-1:0] f_pixel;
  logic [IDX_W-1:0]             f_index;
  logic                         f_last;
  logic [WORD_W-1:0]            q_wdata;
  logic [WORD_W-1:0]            q_rdata;
  logic                         q_empty;
  logic                         q_pop;

  assign accept  = push && !full;
  assign q_wdata = {f_pixel, f_index, f_last};

  nnds_front #(
    .MAX_SRC_DIM(MAX_SRC_DIM),
    .MAX_DST_DIM(MAX_DST_DIM),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_pixel (in_pixel),
    .q_push   (f_push),
    .q_pixel  (f_pixel),
    .q_index  (f_index),
    .q_last   (f_last)
  );

  nnds_queue #(
    .WIDTH(WORD_W),
    .DEPTH(nnds_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .wdata(q_wdata),
    .full (full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  nnds_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pixel      (q_rdata[WORD_W-1 -: nnds_pkg::PIXEL_W]),
    .q_index      (q_rdata[IDX_W:1]),
    .q_last       (q_rdata[0]),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_pixel    (out_pixel),
    .thumb_index  (thumb_index),
    .last_of_frame(last_of_frame)
  );

endmodule

`default_nettype wire
